[rtl/core/ned_pkg.sv]
// Package for the NEC infrared edge decoder: types, register indexes,
// reset values and widths. No dependencies.
`default_nettype none
package ned_pkg;

  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned STAMP_W    = 16;
  localparam int unsigned BIT_CNT_W  = $clog2(FRAME_BITS + 1);
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_LOW_MIN  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_LOW_MAX  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_HIGH_MIN = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_HIGH_MAX = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN       = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN        = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX        = 4'd7;

  localparam logic [CFG_DATA_W-1:0] RST_LEADER_LOW_MIN  = 16'd8000;
  localparam logic [CFG_DATA_W-1:0] RST_LEADER_LOW_MAX  = 16'd10000;
  localparam logic [CFG_DATA_W-1:0] RST_LEADER_HIGH_MIN = 16'd3500;
  localparam logic [CFG_DATA_W-1:0] RST_LEADER_HIGH_MAX = 16'd5500;
  localparam logic [CFG_DATA_W-1:0] RST_SHORT_MIN       = 16'd300;
  localparam logic [CFG_DATA_W-1:0] RST_SHORT_MAX       = 16'd900;
  localparam logic [CFG_DATA_W-1:0] RST_LONG_MIN        = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] RST_LONG_MAX        = 16'd2000;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] leader_low_min;
    logic [CFG_DATA_W-1:0] leader_low_max;
    logic [CFG_DATA_W-1:0] leader_high_min;
    logic [CFG_DATA_W-1:0] leader_high_max;
    logic [CFG_DATA_W-1:0] short_min;
    logic [CFG_DATA_W-1:0] short_max;
    logic [CFG_DATA_W-1:0] long_min;
    logic [CFG_DATA_W-1:0] long_max;
  } ned_cfg_t;

  typedef struct packed {
    logic               cmd;
    logic               pin_level;
    logic [STAMP_W-1:0] timestamp;
  } ned_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              code_ready;
    logic              frame_done;
  } ned_result_t;

  typedef enum logic [1:0] {
    PH_LEADER_LOW  = 2'd0,
    PH_LEADER_HIGH = 2'd1,
    PH_MARK        = 2'd2,
    PH_SPACE       = 2'd3
  } ned_phase_e;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TAKE = 1'b1;

endpackage
`default_nettype wire

[rtl/core/nec_ir_edge_decoder.sv]
// NEC infrared edge decoder, top level: input register, step core, result register.
// Depends on ned_pkg, ned_cfg_regs and ned_core.
//
// Usage: each request on the slave stream is either an edge event (tuser = 0,
// tdata carries pin level and 16-bit tick timestamp) or a take command
// (tuser = 1, clears the ready flag). Every request yields exactly one result
// on the master stream: the held 32-bit code in tdata, code_ready and
// frame_done in tuser.
// The accepting edge loads the input register; the result register loads when the
// result slot is free, which a stalled master stream holds back.
// Throughput: one request per cycle unless the master stream stalls; the step is a
// 16-bit subtract, eight 16-bit compares and a shift between the two registers.
// Window registers are written on the config channel (index 0..7, higher
// indexes ignored); cfg_ready_o is always high. Write only when idle.
// Reset: windows return to their defaults, the decoder waits for a leader,
// code and stamp read zero, and both streams come up empty.
// Stall: while the receiver holds tready low the result register keeps its
// value; one more request may sit in the input register, then tready drops.
`default_nettype none
module nec_ir_edge_decoder (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // slave stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [23:0]                    s_axis_tdata,  // [0] pin_level, [16:1] timestamp
  input  wire logic                           s_axis_tuser,  // [0] cmd
  // master stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [31:0]                         m_axis_tdata,  // [31:0] code
  output logic [1:0]                          m_axis_tuser,  // [0] code_ready, [1] frame_done
  // config write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ned_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ned_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ned_pkg::*;

  ned_cfg_t    cfg;
  ned_item_t   item_q;
  logic        in_vld_q;
  ned_result_t res_d, res_q;
  logic        out_vld_q;
  logic        advance;
  logic        in_take;

  assign cfg_ready_o = 1'b1;

  ned_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // item in the input register moves on when the result slot frees up
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.cmd       <= s_axis_tuser;
      item_q.pin_level <= s_axis_tdata[0];
      item_q.timestamp <= s_axis_tdata[STAMP_W:1];
    end
  end

  ned_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item_q),
    .step_i   (advance),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = res_q.code;
  assign m_axis_tuser[0] = res_q.code_ready;
  assign m_axis_tuser[1] = res_q.frame_done;

endmodule
`default_nettype wire

[rtl/core/ned_cfg_regs.sv]
// Window register file of the NEC edge decoder, written over the config channel.
// Depends on ned_pkg.
`default_nettype none
module ned_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             wr_en_i,
  input  wire logic [ned_pkg::CFG_IDX_W-1:0]    wr_idx_i,
  input  wire logic [ned_pkg::CFG_DATA_W-1:0]   wr_data_i,
  output ned_pkg::ned_cfg_t                     cfg_o
);
  import ned_pkg::*;

  ned_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_low_min  <= RST_LEADER_LOW_MIN;
      cfg_q.leader_low_max  <= RST_LEADER_LOW_MAX;
      cfg_q.leader_high_min <= RST_LEADER_HIGH_MIN;
      cfg_q.leader_high_max <= RST_LEADER_HIGH_MAX;
      cfg_q.short_min       <= RST_SHORT_MIN;
      cfg_q.short_max       <= RST_SHORT_MAX;
      cfg_q.long_min        <= RST_LONG_MIN;
      cfg_q.long_max        <= RST_LONG_MAX;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        REG_LEADER_LOW_MIN:  cfg_q.leader_low_min  <= wr_data_i;
        REG_LEADER_LOW_MAX:  cfg_q.leader_low_max  <= wr_data_i;
        REG_LEADER_HIGH_MIN: cfg_q.leader_high_min <= wr_data_i;
        REG_LEADER_HIGH_MAX: cfg_q.leader_high_max <= wr_data_i;
        REG_SHORT_MIN:       cfg_q.short_min       <= wr_data_i;
        REG_SHORT_MAX:       cfg_q.short_max       <= wr_data_i;
        REG_LONG_MIN:        cfg_q.long_min        <= wr_data_i;
        REG_LONG_MAX:        cfg_q.long_max        <= wr_data_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[rtl/core/ned_core.sv]
// Decoder state and per-edge step logic: interval, window checks, phase walk,
// shift register and held code. Depends on ned_pkg.
`default_nettype none
module ned_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire ned_pkg::ned_cfg_t    cfg_i,
  input  wire ned_pkg::ned_item_t   item_i,
  input  wire logic         step_i,
  output ned_pkg::ned_result_t result_o
);
  import ned_pkg::*;

  ned_phase_e             phase_q, phase_d;
  logic [BIT_CNT_W-1:0]   cnt_q, cnt_d;
  logic [FRAME_BITS-1:0]  shift_q, shift_d;
  logic [STAMP_W-1:0]     stamp_q, stamp_d;
  logic [CODE_W-1:0]      held_q, held_d;
  logic                   ready_q, ready_d;
  logic                   frame_end;

  logic [STAMP_W-1:0]     dticks;
  logic [STAMP_W-1:0]     dus;
  logic                   in_leader_low, in_leader_high, in_short, in_long;
  logic [FRAME_BITS-1:0]  shifted;
  logic [BIT_CNT_W-1:0]   cnt_inc;

  // interval in microseconds, mod 2^16 before and after the times four
  assign dticks = item_i.timestamp - stamp_q;
  assign dus    = {dticks[STAMP_W-3:0], 2'b00};

  assign in_leader_low  = (dus > cfg_i.leader_low_min)  && (dus < cfg_i.leader_low_max);
  assign in_leader_high = (dus > cfg_i.leader_high_min) && (dus < cfg_i.leader_high_max);
  assign in_short       = (dus > cfg_i.short_min)       && (dus < cfg_i.short_max);
  assign in_long        = (dus > cfg_i.long_min)        && (dus < cfg_i.long_max);

  // long window wins over short
  assign shifted = {shift_q[FRAME_BITS-2:0], in_long};
  assign cnt_inc = BIT_CNT_W'(cnt_q + 1'b1);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    shift_d   = shift_q;
    stamp_d   = stamp_q;
    held_d    = held_q;
    ready_d   = ready_q;
    frame_end = 1'b0;
    if (step_i) begin
      if (item_i.cmd == CMD_TAKE) begin
        ready_d = 1'b0;
      end else begin
        stamp_d = item_i.timestamp;
        case (phase_q)
          PH_LEADER_LOW: begin
            if (item_i.pin_level && in_leader_low) begin
              phase_d = PH_LEADER_HIGH;
              cnt_d   = '0;
              shift_d = '0;
            end
          end
          PH_LEADER_HIGH: begin
            phase_d = (!item_i.pin_level && in_leader_high) ? PH_MARK : PH_LEADER_LOW;
          end
          PH_MARK: begin
            phase_d = (item_i.pin_level && in_short) ? PH_SPACE : PH_LEADER_LOW;
          end
          PH_SPACE: begin
            if (item_i.pin_level || !(in_long || in_short)) begin
              phase_d = PH_LEADER_LOW;
            end else begin
              shift_d = shifted;
              cnt_d   = cnt_inc;
              if (cnt_inc >= BIT_CNT_W'(FRAME_BITS)) begin
                held_d    = CODE_W'(shifted);
                ready_d   = 1'b1;
                frame_end = 1'b1;
                phase_d   = PH_LEADER_LOW;
              end else begin
                phase_d = PH_MARK;
              end
            end
          end
          default: phase_d = PH_LEADER_LOW;
        endcase
      end
    end
  end

  always_comb begin
    result_o.code       = held_d;
    result_o.code_ready = ready_d;
    result_o.frame_done = frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEADER_LOW;
      cnt_q   <= '0;
      shift_q <= '0;
      stamp_q <= '0;
      held_q  <= '0;
      ready_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      stamp_q <= stamp_d;
      held_q  <= held_d;
      ready_q <= ready_d;
    end
  end

endmodule
`default_nettype wire
